FILE: hw/rtl/damsu_pkg.sv
// Shared constants, widths and types of the dual ADC moving average scaler.
`default_nettype none

package damsu_pkg;

	// Window geometry and sample format.
	localparam int unsigned WINDOW_LEN  = 10;
	localparam int unsigned SAMPLE_BITS = 12;
	localparam int unsigned FULL_SCALE  = (1 << SAMPLE_BITS) - 1;

	localparam int unsigned SUM_W  = $clog2(WINDOW_LEN * FULL_SCALE + 1);
	localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int unsigned WORD_W = 2 * SAMPLE_BITS;

	// Register widths.
	localparam int unsigned VREF_W  = 13;
	localparam int unsigned RATIO_W = 16;
	localparam int unsigned DROP_W  = 10;
	localparam int unsigned OFFS_W  = 10;
	localparam int unsigned RATIO_FRAC = 12;

	// Register reset values.
	localparam logic [VREF_W-1:0]  VREF_RST  = VREF_W'(3300);
	localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(26438);
	localparam logic [DROP_W-1:0]  DROP_RST  = DROP_W'(400);
	localparam logic [OFFS_W-1:0]  OFFS_RST  = OFFS_W'(500);

	// Register map.
	localparam int unsigned PADDR_W   = 4;
	localparam int unsigned PDATA_W   = 32;
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_VREF  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RATIO = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DROP  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFFS  = 2'd3;

	// Datapath widths.
	localparam int unsigned DIV_D  = WINDOW_LEN * FULL_SCALE;
	localparam int unsigned HALF_D = DIV_D / 2;
	localparam int unsigned D_W    = $clog2(DIV_D + 1);
	localparam int unsigned P1_W   = SUM_W + VREF_W;
	localparam int unsigned P2_W   = P1_W + RATIO_W;
	localparam int unsigned OFF_W  = OFFS_W + D_W;
	localparam int unsigned X_W    = P1_W + 5;
	localparam int unsigned BR_W   = X_W + RATIO_FRAC;
	localparam longint unsigned BATT_ROUND = longint'(DIV_D) << (RATIO_FRAC - 1);

	// Divide by DIV_D through a reciprocal: the dividend is cut to its top bits,
	// multiplied by floor(2^X_W / DIV_D), and the estimate is corrected by at most two.
	localparam int unsigned XS_SH  = D_W - 1;
	localparam int unsigned XS_W   = X_W - XS_SH;
	localparam longint unsigned DIV_M = (64'd1 << X_W) / DIV_D;
	localparam int unsigned M_W    = $clog2(DIV_M + 1);
	localparam int unsigned PR_W   = XS_W + M_W;
	localparam int unsigned Q_W    = XS_W;
	localparam int unsigned QD_W   = Q_W + D_W;

	// Result format and saturation limits.
	localparam int unsigned OUT_W      = 17;
	localparam int unsigned BATT_MAX   = 131071;
	localparam int unsigned TEMP_MAX   = 50000;
	localparam int unsigned TEMP_MIN_M = 20000;
	localparam int unsigned TEMP_SCALE = 10;

	typedef struct packed {
		logic [VREF_W-1:0]  vref_mv;
		logic [RATIO_W-1:0] divider_ratio_q12;
		logic [DROP_W-1:0]  diode_drop_mv;
		logic [OFFS_W-1:0]  sensor_offset_mv;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] bsum;
		logic [SUM_W-1:0] tsum;
		logic             full;
	} win_stat_t;

	typedef struct packed {
		logic           valid;
		logic           tag;
		logic [X_W-1:0] x;
	} div_req_t;

	typedef struct packed {
		logic           valid;
		logic           tag;
		logic [Q_W-1:0] q;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/damsu_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module damsu_regs
	import damsu_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic                 wen;
	logic [REG_IDX_W-1:0] idx;
	cfg_t                 cfg_q;

	assign wen    = psel & penable & pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vref_mv           <= VREF_RST;
			cfg_q.divider_ratio_q12 <= RATIO_RST;
			cfg_q.diode_drop_mv     <= DROP_RST;
			cfg_q.sensor_offset_mv  <= OFFS_RST;
		end else if (wen) begin
			unique case (idx)
				REG_VREF:  cfg_q.vref_mv           <= pwdata[VREF_W-1:0];
				REG_RATIO: cfg_q.divider_ratio_q12 <= pwdata[RATIO_W-1:0];
				REG_DROP:  cfg_q.diode_drop_mv     <= pwdata[DROP_W-1:0];
				REG_OFFS:  cfg_q.sensor_offset_mv  <= pwdata[OFFS_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_VREF:  prdata = PDATA_W'(cfg_q.vref_mv);
			REG_RATIO: prdata = PDATA_W'(cfg_q.divider_ratio_q12);
			REG_DROP:  prdata = PDATA_W'(cfg_q.diode_drop_mv);
			REG_OFFS:  prdata = PDATA_W'(cfg_q.sensor_offset_mv);
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/damsu_window.sv
// Sample ring memory and running sums for both channels.
`default_nettype none

module damsu_window
	import damsu_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [SAMPLE_BITS-1:0] battery_sample,
	input  wire logic [SAMPLE_BITS-1:0] thermistor_sample,
	output win_stat_t                   stat
);

	logic [WORD_W-1:0]      ring [WINDOW_LEN];
	logic [WORD_W-1:0]      rd_q;
	logic [SAMPLE_BITS-1:0] bnew_s1;
	logic [SAMPLE_BITS-1:0] tnew_s1;
	logic                   upd_s1;
	logic [SLOT_W-1:0]      slot_q;
	logic [FILL_W-1:0]      fill_q;
	logic [SUM_W-1:0]       bsum_q;
	logic [SUM_W-1:0]       tsum_q;
	logic                   full_q;
	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] bold;
	logic [SAMPLE_BITS-1:0] told;
	logic                   filling;
	logic [FILL_W-1:0]      fill_nxt;

	// Until the window has wrapped once, the slot being overwritten was never
	// written and counts as zero.
	assign filling  = (fill_q < FILL_W'(WINDOW_LEN));
	assign bold     = filling ? '0 : rd_q[WORD_W-1:SAMPLE_BITS];
	assign told     = filling ? '0 : rd_q[SAMPLE_BITS-1:0];
	assign fill_nxt = filling ? fill_q + 1'b1 : fill_q;

	// The read is issued when the item is taken and the write follows in the next
	// cycle; the next item cannot arrive before that write, so no forwarding.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= ring[slot_q];
		end
		if (upd_s1) begin
			ring[slot_q] <= {bnew_s1, tnew_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bnew_s1 <= battery_sample;
			tnew_s1 <= thermistor_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1  <= 1'b0;
			valid_q <= 1'b0;
			slot_q  <= '0;
			fill_q  <= '0;
			bsum_q  <= '0;
			tsum_q  <= '0;
			full_q  <= 1'b0;
		end else begin
			upd_s1  <= accept;
			valid_q <= upd_s1;
			if (upd_s1) begin
				bsum_q <= bsum_q - SUM_W'(bold) + SUM_W'(bnew_s1);
				tsum_q <= tsum_q - SUM_W'(told) + SUM_W'(tnew_s1);
				slot_q <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
				fill_q <= fill_nxt;
				full_q <= (fill_nxt == FILL_W'(WINDOW_LEN));
			end
		end
	end

	assign stat.valid = valid_q;
	assign stat.bsum  = bsum_q;
	assign stat.tsum  = tsum_q;
	assign stat.full  = full_q;

endmodule

`default_nettype wire

FILE: hw/rtl/damsu_cdiv.sv
// Three-stage pipelined divider by the window full-scale constant.
`default_nettype none

module damsu_cdiv
	import damsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);

	localparam logic [M_W-1:0] MUL_C = M_W'(DIV_M);
	localparam logic [X_W-1:0] D1_C  = X_W'(DIV_D);
	localparam logic [X_W-1:0] D2_C  = X_W'(2 * DIV_D);

	logic [PR_W-1:0] prod_s1;
	logic [X_W-1:0]  x_s1;
	logic            tag_s1;
	logic            v_s1;
	logic [Q_W-1:0]  qest_s2;
	logic [QD_W-1:0] qd_s2;
	logic [X_W-1:0]  x_s2;
	logic            tag_s2;
	logic            v_s2;
	logic [Q_W-1:0]  q_s3;
	logic            tag_s3;
	logic            v_s3;
	logic [Q_W-1:0]  qest;
	logic [X_W-1:0]  rem;

	assign qest = prod_s1[XS_W +: Q_W];
	assign rem  = x_s2 - qd_s2[X_W-1:0];

	always_ff @(posedge clk) begin
		prod_s1 <= PR_W'(req.x[X_W-1:XS_SH]) * PR_W'(MUL_C);
		x_s1    <= req.x;
		tag_s1  <= req.tag;
		qest_s2 <= qest;
		qd_s2   <= QD_W'(qest) * QD_W'(DIV_D);
		x_s2    <= x_s1;
		tag_s2  <= tag_s1;
		tag_s3  <= tag_s2;
		// The estimate is low by at most two.
		if (rem >= D2_C) begin
			q_s3 <= qest_s2 + Q_W'(2);
		end else if (rem >= D1_C) begin
			q_s3 <= qest_s2 + Q_W'(1);
		end else begin
			q_s3 <= qest_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign rsp.valid = v_s3;
	assign rsp.tag   = tag_s3;
	assign rsp.q     = q_s3;

endmodule

`default_nettype wire

FILE: hw/rtl/damsu_scale.sv
// Scaling of the averaged sums to millivolts and centidegrees.
`default_nettype none

module damsu_scale
	import damsu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  win_stat_t             stat,
	input  cfg_t                  cfg,
	output logic                  res_valid,
	output logic [OUT_W-1:0]      res_batt,
	output logic [OUT_W-1:0]      res_temp
);

	logic [P1_W-1:0]  pb_s1;
	logic [P1_W-1:0]  pt_s1;
	logic [OFF_W-1:0] off_s1;
	logic             v_s1;
	logic [P2_W-1:0]  pb_s2;
	logic [P1_W:0]    d_s2;
	logic             v_s2;
	logic [X_W-1:0]   xb_s3;
	logic [X_W-1:0]   xt_s3;
	logic             neg_s3;
	logic             v_s3;
	logic             v_s4;
	logic [Q_W-1:0]   qb_q;
	logic             res_valid_q;
	logic [OUT_W-1:0] batt_q;
	logic [OUT_W-1:0] temp_q;

	logic [BR_W-1:0]  brnd;
	logic [P1_W:0]    dneg;
	logic [P1_W-1:0]  dmag;
	logic [X_W-1:0]   dmag_x;
	logic [Q_W:0]     bsum;
	logic [Q_W-1:0]   tmag;
	logic [OUT_W-1:0] tmag_o;
	div_req_t         dreq;
	div_rsp_t         drsp;

	assign brnd   = BR_W'(pb_s2) + BR_W'(BATT_ROUND);
	assign dneg   = -d_s2;
	assign dmag   = d_s2[P1_W] ? dneg[P1_W-1:0] : d_s2[P1_W-1:0];
	assign dmag_x = X_W'(dmag);

	always_ff @(posedge clk) begin
		if (stat.valid) begin
			pb_s1  <= P1_W'(stat.bsum) * P1_W'(cfg.vref_mv);
			pt_s1  <= P1_W'(stat.tsum) * P1_W'(cfg.vref_mv);
			off_s1 <= OFF_W'(cfg.sensor_offset_mv) * OFF_W'(DIV_D);
		end
		if (v_s1) begin
			pb_s2 <= P2_W'(pb_s1) * P2_W'(cfg.divider_ratio_q12);
			d_s2  <= {1'b0, pb_s1[P1_W-1:0] & '0} | ({1'b0, pt_s1} - (P1_W + 1)'(off_s1));
		end
		if (v_s2) begin
			// Battery: round half up, then drop the Q12 fraction.
			xb_s3  <= brnd[BR_W-1:RATIO_FRAC];
			// Temperature: ten times the magnitude, round half away from zero.
			xt_s3  <= (dmag_x << 3) + (dmag_x << 1) + X_W'(HALF_D);
			neg_s3 <= d_s2[P1_W];
		end
		if (drsp.valid && !drsp.tag) begin
			qb_q <= drsp.q;
		end
		if (drsp.valid && drsp.tag) begin
			batt_q <= (bsum > (Q_W + 1)'(BATT_MAX)) ? OUT_W'(BATT_MAX) : bsum[OUT_W-1:0];
			temp_q <= neg_s3 ? (OUT_W'(0) - tmag_o) : tmag_o;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1        <= stat.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			res_valid_q <= drsp.valid & drsp.tag;
		end
	end

	// The battery quotient goes first, the temperature quotient in the cycle after.
	assign dreq.valid = v_s3 | v_s4;
	assign dreq.tag   = v_s4;
	assign dreq.x     = v_s3 ? xb_s3 : xt_s3;

	damsu_cdiv u_cdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		bsum = (Q_W + 1)'(qb_q) + (Q_W + 1)'(cfg.diode_drop_mv);
		if (neg_s3) begin
			tmag = (drsp.q > Q_W'(TEMP_MIN_M)) ? Q_W'(TEMP_MIN_M) : drsp.q;
		end else begin
			tmag = (drsp.q > Q_W'(TEMP_MAX)) ? Q_W'(TEMP_MAX) : drsp.q;
		end
		tmag_o = OUT_W'(tmag);
	end

	assign res_valid = res_valid_q;
	assign res_batt  = batt_q;
	assign res_temp  = temp_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dual_adc_moving_average_scaler_unit.sv
// Top level of the dual ADC moving average scaler.
//
// Each input item carries one battery count and one temperature sensor count.
// Both counts enter a ten-deep ring per channel held in one synchronous memory;
// the running sums drop the oldest count and add the new one. The averaged
// battery count is scaled to millivolts through vref and the Q4.12 divider
// ratio plus the diode drop, and the temperature count to hundredths of a
// degree; both results saturate. window_full rises once ten items have entered.
// Both channels use a valid/ready handshake. One item is worked on at a time:
// a new item can be taken in the cycle after the result enters the output
// register, so the block does not take a new item until it is through with
// the last one. The time per item is set by the ring read-modify-write, the
// two multiply stages and the shared three-stage divider, which handles the
// battery quotient and then the temperature quotient in the following cycle.
// While the receiver stalls, the output register holds its item and a
// finished result waits in the scaler; no further item is taken.
// Reset clears the sums, the ring pointer and fill count, and restores the
// register defaults; ring entries not yet written count as zero.
`default_nettype none

module dual_adc_moving_average_scaler_unit
	import damsu_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [PADDR_W-1:0]     paddr,
	input  wire logic [PDATA_W-1:0]     pwdata,
	output logic      [PDATA_W-1:0]     prdata,
	output logic                        pready,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] battery_sample,
	input  wire logic [SAMPLE_BITS-1:0] thermistor_sample,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [OUT_W-1:0]       battery_mv,
	output logic signed [OUT_W-1:0]     temperature_centi_c,
	output logic                        window_full
);

	cfg_t             cfg;
	win_stat_t        stat;
	logic             accept;
	logic             busy_q;
	logic             pend_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] batt_q;
	logic [OUT_W-1:0] temp_q;
	logic             full_q;
	logic             res_valid;
	logic [OUT_W-1:0] res_batt;
	logic [OUT_W-1:0] res_temp;
	logic             have_res;
	logic             load;

	assign in_ready = ~busy_q;
	assign accept   = in_valid & in_ready;

	damsu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	damsu_window u_window (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.battery_sample    (battery_sample),
		.thermistor_sample (thermistor_sample),
		.stat              (stat)
	);

	damsu_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res_batt  (res_batt),
		.res_temp  (res_temp)
	);

	// The scaler keeps its result registers until the next item finishes, so a
	// result that meets a full output register only needs a pending flag.
	assign have_res = res_valid | pend_q;
	assign load     = have_res & (~out_valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= have_res & ~load;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The window status stays put until the next item, which waits for this load.
	always_ff @(posedge clk) begin
		if (load) begin
			batt_q <= res_batt;
			temp_q <= res_temp;
			full_q <= stat.full;
		end
	end

	assign out_valid           = out_valid_q;
	assign battery_mv          = batt_q;
	assign temperature_centi_c = $signed(temp_q);
	assign window_full         = full_q;

endmodule

`default_nettype wire

FILE: hw/rtl/damsu_checker.sv
// Port-level checks of the dual ADC moving average scaler, bound to the top level.
`default_nettype none

module damsu_checker
	import damsu_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic [OUT_W-1:0]        battery_mv,
	input wire logic signed [OUT_W-1:0] temperature_centi_c,
	input wire logic                    window_full
);

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(battery_mv)
			&& $stable(temperature_centi_c) && $stable(window_full))
		else $error("output item changed while stalled");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	// A fresh result frees the input side in the same cycle.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $rose(in_ready))
		else $error("result appeared without finishing an item");

	// Temperature stays inside its saturation limits.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (temperature_centi_c >= -$signed(OUT_W'(TEMP_MIN_M)))
			&& (temperature_centi_c <= $signed(OUT_W'(TEMP_MAX))))
		else $error("temperature outside its limits");

endmodule

bind dual_adc_moving_average_scaler_unit damsu_checker u_damsu_checker (.*);

`default_nettype wire

FILE: tb/tb_dual_adc_moving_average_scaler_unit.sv
// Self-checking testbench for the dual ADC moving average scaler: handshake drivers, APB writes and a scoreboard.
module tb_dual_adc_moving_average_scaler_unit;
	import damsu_pkg::*;

	// The run stops here even if the handshakes hang. The worst case is about
	// 1900 items, and this limit is several times over that run.
	localparam int unsigned CYCLE_LIMIT = 600000;
	// Length of the single long receiver hold-off that backs the block up.
	localparam int unsigned LONG_HOLD = 400;
	// Cycles allowed for an item to clear the pipeline.
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned PHASE_ITEMS = 230;
	localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

	// Each stretch of the receiver follows one of these ready patterns.
	typedef enum int unsigned {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_MOSTLY,
		RDY_PERIODIC
	} ready_mode_e;

	// Each burst of the sender draws its samples in one of these ways.
	typedef enum int unsigned {
		MIX_UNIFORM,
		MIX_EXTREME,
		MIX_STEADY,
		MIX_LOW
	} sample_mix_e;

	// One expected output item.
	typedef struct packed {
		logic [OUT_W-1:0] mv;
		logic [OUT_W-1:0] centi;
		logic             full;
	} reading_t;

	// The scoreboard keeps its own copy of the registers, both sample rings and
	// the running sums. Every accepted input item yields exactly one expected
	// reading, and readings leave the block in order.
	class reading_scoreboard;
		logic [VREF_W-1:0]      vref;
		logic [RATIO_W-1:0]     ratio;
		logic [DROP_W-1:0]      drop;
		logic [OFFS_W-1:0]      offs;
		logic [SAMPLE_BITS-1:0] batt_ring[WINDOW_LEN];
		logic [SAMPLE_BITS-1:0] therm_ring[WINDOW_LEN];
		int unsigned            batt_sum;
		int unsigned            therm_sum;
		int unsigned            slot;
		int unsigned            filled;
		reading_t               expected_q[$];
		int unsigned            errors;

		function new();
			vref = VREF_RST;
			ratio = RATIO_RST;
			drop = DROP_RST;
			offs = OFFS_RST;
			for (int i = 0; i < WINDOW_LEN; i++) begin
				batt_ring[i] = '0;
				therm_ring[i] = '0;
			end
			batt_sum = 0;
			therm_sum = 0;
			slot = 0;
			filled = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_VREF:  vref = value[VREF_W-1:0];
				REG_RATIO: ratio = value[RATIO_W-1:0];
				REG_DROP:  drop = value[DROP_W-1:0];
				REG_OFFS:  offs = value[OFFS_W-1:0];
				default: ;
			endcase
		endfunction

		// Average counts to millivolts through vref and the Q4.12 divider ratio,
		// rounded half up, plus the diode drop, clamped to the output range.
		function logic [OUT_W-1:0] battery_millivolts(int unsigned sum);
			longint unsigned den;
			longint unsigned num;
			longint unsigned mv;
			den = 64'(WINDOW_LEN) * 64'(FULL_SCALE) * 64'd4096;
			num = 64'(sum) * 64'(vref) * 64'(ratio);
			mv = (num + den / 2) / den + 64'(drop);
			if (mv > 64'(BATT_MAX))
				mv = 64'(BATT_MAX);
			return OUT_W'(mv);
		endfunction

		// Pin millivolts minus the sensor offset, times ten, rounded half away
		// from zero and clamped on both sides.
		function logic [OUT_W-1:0] centi_celsius(int unsigned sum);
			longint unsigned den;
			longint unsigned val;
			longint unsigned off;
			longint unsigned q;
			longint          centi;
			den = 64'(WINDOW_LEN) * 64'(FULL_SCALE);
			val = 64'(sum) * 64'(vref) * 64'(TEMP_SCALE);
			off = 64'(offs) * 64'(TEMP_SCALE) * den;
			if (val >= off) begin
				q = (val - off + den / 2) / den;
				if (q > 64'(TEMP_MAX))
					q = 64'(TEMP_MAX);
				centi = longint'(q);
			end else begin
				q = (off - val + den / 2) / den;
				if (q > 64'(TEMP_MIN_M))
					q = 64'(TEMP_MIN_M);
				centi = -longint'(q);
			end
			return OUT_W'(centi);
		endfunction

		function void note_pair(logic [SAMPLE_BITS-1:0] batt, logic [SAMPLE_BITS-1:0] therm);
			reading_t r;
			batt_sum = batt_sum - batt_ring[slot] + batt;
			therm_sum = therm_sum - therm_ring[slot] + therm;
			batt_ring[slot] = batt;
			therm_ring[slot] = therm;
			slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
			if (filled < WINDOW_LEN)
				filled++;
			r.mv = battery_millivolts(batt_sum);
			r.centi = centi_celsius(therm_sum);
			r.full = (filled >= WINDOW_LEN);
			expected_q.push_back(r);
		endfunction

		function void check_reading(logic [OUT_W-1:0] mv, logic [OUT_W-1:0] centi, logic full);
			reading_t r;
			if (expected_q.size() == 0) begin
				$error("output item with none expected: battery_mv=%0d temperature_centi_c=%0d",
					mv, $signed(centi));
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (mv !== r.mv) begin
				$error("battery_mv expected %0d actual %0d", r.mv, mv);
				errors++;
			end
			if (centi !== r.centi) begin
				$error("temperature_centi_c expected %0d actual %0d",
					$signed(r.centi), $signed(centi));
				errors++;
			end
			if (full !== r.full) begin
				$error("window_full expected %0b actual %0b", r.full, full);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;
	logic                   in_valid;
	logic                   in_ready;
	logic [SAMPLE_BITS-1:0] battery_sample;
	logic [SAMPLE_BITS-1:0] thermistor_sample;
	logic                   out_valid;
	logic                   out_ready;
	logic [OUT_W-1:0]       battery_mv;
	logic signed [OUT_W-1:0] temperature_centi_c;
	logic                   window_full;

	// Set by the stimulus to ask the receiver for its long hold-off.
	bit                     long_hold_req;
	int unsigned            cycle_count;
	reading_scoreboard      sb = new();

	dual_adc_moving_average_scaler_unit u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.battery_sample      (battery_sample),
		.thermistor_sample   (thermistor_sample),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.battery_mv          (battery_mv),
		.temperature_centi_c (temperature_centi_c),
		.window_full         (window_full)
	);

	always #1 clk = ~clk;

	// Timeout guard. A hung handshake ends the run here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL dual_adc_moving_average_scaler_unit");
			$finish;
		end
	end

	// Output monitor. An item leaves at a rising edge where valid and ready
	// are both high; the values read here are the ones from before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_reading(battery_mv, temperature_centi_c, window_full);
	end

	// Receiver. It walks through stretches of random length, each with its own
	// ready pattern, so stalls land on every phase of the block's work. When
	// asked, it drops ready for a long hold-off that it counts itself, which
	// lets the pipeline and the output register fill so the input side stalls.
	initial begin : receiver
		int unsigned left;
		int unsigned period;
		ready_mode_e mode;
		left = 0;
		period = 2;
		mode = RDY_ALWAYS;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (left == 0) begin
					left = $urandom_range(20, 200);
					period = $urandom_range(2, 8);
					mode = ready_mode_e'($urandom_range(0, 3));
				end
				left--;
				case (mode)
					RDY_ALWAYS:  out_ready <= 1'b1;
					RDY_COIN:    out_ready <= 1'($urandom_range(0, 1));
					RDY_MOSTLY:  out_ready <= ($urandom_range(0, 7) != 0);
					default:     out_ready <= ((left % period) == 0);
				endcase
			end
		end
	end

	// Offer one sample pair and hold it until the block takes it. Inputs move
	// on the falling edge; acceptance is judged at the rising edge.
	task automatic drive_pair(input logic [SAMPLE_BITS-1:0] batt,
		input logic [SAMPLE_BITS-1:0] therm);
		@(negedge clk);
		in_valid <= 1'b1;
		battery_sample <= batt;
		thermistor_sample <= therm;
		do @(posedge clk); while (!in_ready);
		sb.note_pair(batt, therm);
	endtask

	// Leave the input idle for a number of cycles, with junk on the data lines.
	task automatic idle_input(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
			battery_sample <= SAMPLE_BITS'($urandom);
			thermistor_sample <= SAMPLE_BITS'($urandom);
		end
	endtask

	// Bring the block to rest: stop offering, collect every expected reading
	// and let the pipeline settle before a register is touched.
	task automatic drain();
		idle_input(1);
		while (sb.pending() != 0)
			@(posedge clk);
		idle_input(SETTLE_CYCLES);
	endtask

	// APB write: a setup cycle, then an access cycle that completes at the
	// rising edge where pready is high.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [PDATA_W-1:0] vref, input logic [PDATA_W-1:0] ratio,
		input logic [PDATA_W-1:0] drop, input logic [PDATA_W-1:0] offs);
		drain();
		write_reg(REG_VREF, vref);
		write_reg(REG_RATIO, ratio);
		write_reg(REG_DROP, drop);
		write_reg(REG_OFFS, offs);
	endtask

	// A random register value: mostly inside the stated range, sometimes a
	// whole random word whose upper bits the register has to drop.
	function automatic logic [PDATA_W-1:0] pick_reg(input int unsigned lo, input int unsigned hi);
		if ($urandom_range(0, 3) == 0)
			return PDATA_W'($urandom);
		return PDATA_W'($urandom_range(lo, hi));
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sample_mix_e mix,
		input int unsigned level);
		int signed v;
		case (mix)
			MIX_EXTREME: return $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
			MIX_LOW:     return SAMPLE_BITS'($urandom_range(0, 63));
			MIX_STEADY: begin
				// A level with a little noise so the average settles anywhere.
				v = int'(level) + int'($urandom_range(0, 31)) - 16;
				if (v < 0)
					v = 0;
				if (v > int'(SAMPLE_MAX))
					v = SAMPLE_MAX;
				return SAMPLE_BITS'(v);
			end
			default:     return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Random traffic in bursts. Each burst has its own sample mix and levels,
	// and random gaps fall between bursts. With steady_offer set the sender
	// never pauses, which is used while the receiver holds off.
	task automatic run_phase(input int unsigned count, input bit steady_offer);
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		int unsigned batt_level;
		int unsigned therm_level;
		sample_mix_e mix;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			mix = sample_mix_e'($urandom_range(0, 3));
			batt_level = $urandom_range(0, SAMPLE_MAX);
			therm_level = $urandom_range(0, SAMPLE_MAX);
			for (int k = 0; k < burst && sent < count; k++) begin
				drive_pair(pick_sample(mix, batt_level), pick_sample(mix, therm_level));
				sent++;
			end
			gap = 0;
			if (!steady_offer && $urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 14);
			if (gap != 0)
				idle_input(gap);
		end
	endtask

	initial begin : stimulus
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		battery_sample = '0;
		thermistor_sample = '0;
		out_ready = 1'b0;
		long_hold_req = 1'b0;
		cycle_count = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset register values. The first items run
		// while the window is still filling, so unwritten slots count as zero
		// and window_full stays low; it rises on the tenth item.
		drive_pair('0, '0);
		drive_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX));
		drive_pair(SAMPLE_BITS'(SAMPLE_MAX), '0);
		drive_pair('0, SAMPLE_BITS'(SAMPLE_MAX));
		drive_pair(12'hAAA, 12'h555);
		drive_pair(12'h555, 12'hAAA);
		repeat (4)
			drive_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX));
		// The ring wraps here and the zero pair from the start leaves the sums.
		repeat (10)
			drive_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX));
		drive_pair(12'd1, 12'd1);
		drive_pair(12'd2048, 12'd2048);
		drive_pair('0, '0);

		// Bottom of every stated range. The receiver's long hold-off is asked
		// for here while the sender keeps offering items without gaps.
		set_config(1000, 4096, 0, 0);
		long_hold_req = 1'b1;
		run_phase(PHASE_ITEMS, 1'b1);

		// Top of every stated range.
		set_config(5000, 65535, 1000, 1000);
		run_phase(PHASE_ITEMS, 1'b0);

		// All ones in every register: both results reach their upper clamps.
		set_config((1 << VREF_W) - 1, (1 << RATIO_W) - 1, (1 << DROP_W) - 1,
			(1 << OFFS_W) - 1);
		run_phase(PHASE_ITEMS, 1'b0);

		// Zero reference and ratio with the largest offset: battery falls to
		// zero and the temperature stays deep below zero.
		set_config(0, 0, 0, (1 << OFFS_W) - 1);
		run_phase(PHASE_ITEMS, 1'b0);

		repeat (4) begin
			set_config(pick_reg(1000, 5000), pick_reg(4096, 65535), pick_reg(0, 1000),
				pick_reg(0, 1000));
			run_phase(PHASE_ITEMS, 1'b0);
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS dual_adc_moving_average_scaler_unit");
		else
			$display("FAIL dual_adc_moving_average_scaler_unit");
		$finish;
	end

endmodule
